/* hw/rtl/mmh2_pkg.sv */
// shared types and constants for the murmurhash2 stream hasher
// used by mmh2_ctrl, mmh2_datapath and murmur2_stream_hash
`default_nettype none

package mmh2_pkg;

    localparam int unsigned WORD_W  = 32;
    localparam int unsigned SHIFT_W = 5;
    localparam int unsigned COUNT_W = 3;
    localparam int unsigned CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_SEED       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MULTIPLIER = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SHIFT      = 2'd2;

    localparam logic OP_START = 1'b0;
    localparam logic OP_DATA  = 1'b1;

    localparam logic [WORD_W-1:0]  SEED_RESET  = 32'h0000_0000;
    localparam logic [WORD_W-1:0]  MULT_RESET  = 32'h5BD1_E995;
    localparam logic [SHIFT_W-1:0] SHIFT_RESET = 5'd24;
    localparam logic [WORD_W-1:0]  LEN_ALL_ONES = 32'hFFFF_FFFF;

    localparam int unsigned FIN_SHIFT_A = 13;
    localparam int unsigned FIN_SHIFT_B = 15;

    localparam logic [COUNT_W-1:0] FULL_COUNT = 3'd4;

    typedef enum logic [2:0] {
        MUL_WORD,
        MUL_KMIX,
        MUL_HASH,
        MUL_TAIL,
        MUL_FIN
    } t_mul_sel;

    typedef struct packed {
        logic     init_hash;
        logic     load_word;
        logic     mul_en;
        t_mul_sel mul_sel;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
    } t_dp_status;

endpackage

`default_nettype wire

/* hw/rtl/murmur2_stream_hash.sv */
// murmurhash2 (32-bit) stream hasher, top level
// depends on mmh2_pkg, mmh2_ctrl and mmh2_datapath
//
// A start item (op 0) opens a message with its byte length; data items (op 1)
// bring up to four bytes each, first byte in the low bits. One 32x32 multiplier
// is shared by every multiply, so the cost per item follows the multiply count:
// a start item needs no multiply, a full data word takes the accept plus three
// multiplies, a tail word of 1 to 3 bytes the accept plus one multiply, and a
// message end adds a finalising multiply. The result sits in an output register,
// so the next item is taken while a finished hash still waits; a second result
// stalls only in the finalising state until that register is free.
`default_nettype none

module murmur2_stream_hash (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_valid,
    output logic                                   o_ready,
    input  wire logic                              i_op,
    input  wire logic [mmh2_pkg::WORD_W-1:0]       i_total_length,
    input  wire logic [mmh2_pkg::WORD_W-1:0]       i_data_word,
    input  wire logic [mmh2_pkg::COUNT_W-1:0]      i_byte_count,
    input  wire logic                              i_last,
    output logic                                   o_valid,
    input  wire logic                              i_ready,
    output logic [mmh2_pkg::WORD_W-1:0]            o_hash_value,
    input  wire logic                              i_cfg_we,
    input  wire logic [mmh2_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [mmh2_pkg::WORD_W-1:0]       i_cfg_data
);

    mmh2_pkg::t_dp_cmd    cmd;
    mmh2_pkg::t_dp_status status;

    mmh2_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_op         (i_op),
        .i_len_zero   (i_total_length == '0),
        .i_byte_count (i_byte_count),
        .i_last       (i_last),
        .i_status     (status),
        .o_cmd        (cmd)
    );

    mmh2_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_total_length (i_total_length),
        .i_data_word    (i_data_word),
        .i_byte_count   (i_byte_count),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_out_ready    (i_ready),
        .o_out_valid    (o_valid),
        .o_hash_value   (o_hash_value)
    );

    // a start with a non-zero length returns straight to accepting
    a_start_no_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && i_op == mmh2_pkg::OP_START && i_total_length != '0)
        |=> o_ready)
        else $error("start item with length stalled the input");

    // a new result always follows a busy finalising cycle
    a_result_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(!o_ready))
        else $error("result appeared without a finalising cycle");

    // a pending result stays valid until it is taken
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> o_valid)
        else $error("pending result dropped");

endmodule

`default_nettype wire

/* hw/rtl/mmh2_datapath.sv */
// datapath: config registers, running hash, one shared 32x32 multiplier, result register
// depends on mmh2_pkg
`default_nettype none

module mmh2_datapath (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [mmh2_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [mmh2_pkg::WORD_W-1:0]       i_cfg_data,
    input  wire logic [mmh2_pkg::WORD_W-1:0]       i_total_length,
    input  wire logic [mmh2_pkg::WORD_W-1:0]       i_data_word,
    input  wire logic [mmh2_pkg::COUNT_W-1:0]      i_byte_count,
    input  wire mmh2_pkg::t_dp_cmd                 i_cmd,
    output mmh2_pkg::t_dp_status                   o_status,
    input  wire logic                              i_out_ready,
    output logic                                   o_out_valid,
    output logic [mmh2_pkg::WORD_W-1:0]            o_hash_value
);

    logic [mmh2_pkg::WORD_W-1:0]  r_seed;
    logic [mmh2_pkg::WORD_W-1:0]  r_mult;
    logic [mmh2_pkg::SHIFT_W-1:0] r_shift;
    logic [mmh2_pkg::WORD_W-1:0]  r_h;
    logic [mmh2_pkg::WORD_W-1:0]  r_k;
    logic [mmh2_pkg::WORD_W-1:0]  r_w;
    logic [1:0]                   r_tail_cnt;
    logic                         r_out_valid;
    logic [mmh2_pkg::WORD_W-1:0]  r_hash_out;

    logic [mmh2_pkg::WORD_W-1:0]   tail_mask;
    logic [mmh2_pkg::WORD_W-1:0]   mul_a;
    logic [2*mmh2_pkg::WORD_W-1:0] mul_full;
    logic [mmh2_pkg::WORD_W-1:0]   prod;
    logic [mmh2_pkg::WORD_W-1:0]   eff_len;
    logic                          out_load;

    always_comb begin
        unique case (r_tail_cnt)
            2'd1:    tail_mask = 32'h0000_00FF;
            2'd2:    tail_mask = 32'h0000_FFFF;
            2'd3:    tail_mask = 32'h00FF_FFFF;
            default: tail_mask = 32'hFFFF_FFFF;
        endcase
    end

    always_comb begin
        unique case (i_cmd.mul_sel)
            mmh2_pkg::MUL_WORD: mul_a = r_w;
            mmh2_pkg::MUL_KMIX: mul_a = r_k ^ (r_k >> r_shift);
            mmh2_pkg::MUL_HASH: mul_a = r_h;
            mmh2_pkg::MUL_TAIL: mul_a = r_h ^ (r_w & tail_mask);
            mmh2_pkg::MUL_FIN:  mul_a = r_h ^ (r_h >> mmh2_pkg::FIN_SHIFT_A);
            default:            mul_a = r_h;
        endcase
    end

    assign mul_full = {{mmh2_pkg::WORD_W{1'b0}}, mul_a} * {{mmh2_pkg::WORD_W{1'b0}}, r_mult};
    assign prod     = mul_full[mmh2_pkg::WORD_W-1:0];
    assign eff_len  = (i_total_length == mmh2_pkg::LEN_ALL_ONES) ? '0 : i_total_length;

    assign o_status.out_free = !r_out_valid || i_out_ready;
    assign out_load = i_cmd.mul_en && (i_cmd.mul_sel == mmh2_pkg::MUL_FIN);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed      <= mmh2_pkg::SEED_RESET;
            r_mult      <= mmh2_pkg::MULT_RESET;
            r_shift     <= mmh2_pkg::SHIFT_RESET;
            r_h         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    mmh2_pkg::CFG_SEED:       r_seed  <= i_cfg_data;
                    mmh2_pkg::CFG_MULTIPLIER: r_mult  <= i_cfg_data;
                    mmh2_pkg::CFG_SHIFT:      r_shift <= i_cfg_data[mmh2_pkg::SHIFT_W-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.init_hash) begin
                r_h <= r_seed ^ eff_len;
            end else if (i_cmd.mul_en && i_cmd.mul_sel == mmh2_pkg::MUL_HASH) begin
                r_h <= prod ^ r_k;
            end else if (i_cmd.mul_en && i_cmd.mul_sel == mmh2_pkg::MUL_TAIL) begin
                r_h <= prod;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_word) begin
            r_w        <= i_data_word;
            r_tail_cnt <= i_byte_count[1:0];
        end
        if (i_cmd.mul_en && (i_cmd.mul_sel == mmh2_pkg::MUL_WORD ||
                             i_cmd.mul_sel == mmh2_pkg::MUL_KMIX)) begin
            r_k <= prod;
        end
        if (out_load) begin
            r_hash_out <= prod ^ (prod >> mmh2_pkg::FIN_SHIFT_B);
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_hash_value = r_hash_out;

endmodule

`default_nettype wire

/* hw/rtl/mmh2_ctrl.sv */
// controller: sequences the shared multiplier and tracks the open message
// depends on mmh2_pkg
`default_nettype none

module mmh2_ctrl (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic                          i_op,
    input  wire logic                          i_len_zero,
    input  wire logic [mmh2_pkg::COUNT_W-1:0]  i_byte_count,
    input  wire logic                          i_last,
    input  wire mmh2_pkg::t_dp_status          i_status,
    output mmh2_pkg::t_dp_cmd                  o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_K1,
        S_K2,
        S_HMIX,
        S_TAIL,
        S_FIN
    } t_state;

    t_state r_state;
    logic   r_in_msg;
    logic   r_last;

    logic accept;
    logic cnt_full;
    logic cnt_zero;

    assign o_ready  = (r_state == S_IDLE);
    assign accept   = i_valid && o_ready;
    assign cnt_full = (i_byte_count >= mmh2_pkg::FULL_COUNT);
    assign cnt_zero = (i_byte_count == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_in_msg <= 1'b0;
            r_last   <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        if (i_op == mmh2_pkg::OP_START) begin
                            r_in_msg <= !i_len_zero;
                            r_state  <= i_len_zero ? S_FIN : S_IDLE;
                        end else if (r_in_msg) begin
                            r_last <= i_last;
                            if (cnt_full) begin
                                r_state <= S_K1;
                            end else if (!cnt_zero) begin
                                r_in_msg <= 1'b0;
                                r_state  <= S_TAIL;
                            end else if (i_last) begin
                                r_in_msg <= 1'b0;
                                r_state  <= S_FIN;
                            end
                        end
                    end
                end
                S_K1: r_state <= S_K2;
                S_K2: r_state <= S_HMIX;
                S_HMIX: begin
                    if (r_last) begin
                        r_in_msg <= 1'b0;
                        r_state  <= S_FIN;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_TAIL: r_state <= S_FIN;
                S_FIN: begin
                    if (i_status.out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_comb begin
        o_cmd.init_hash = accept && (i_op == mmh2_pkg::OP_START);
        o_cmd.load_word = accept && (i_op == mmh2_pkg::OP_DATA);
        o_cmd.mul_en    = 1'b0;
        o_cmd.mul_sel   = mmh2_pkg::MUL_WORD;
        unique case (r_state)
            S_K1: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = mmh2_pkg::MUL_WORD;
            end
            S_K2: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = mmh2_pkg::MUL_KMIX;
            end
            S_HMIX: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = mmh2_pkg::MUL_HASH;
            end
            S_TAIL: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = mmh2_pkg::MUL_TAIL;
            end
            S_FIN: begin
                o_cmd.mul_en  = i_status.out_free;
                o_cmd.mul_sel = mmh2_pkg::MUL_FIN;
            end
            default: ;
        endcase
    end

endmodule

`default_nettype wire

/* tb/tb_top.sv */
// self-checking testbench for murmur2_stream_hash: drives start and data items,
// predicts each 32-bit hash in step with the accepted items and compares results
// depends on mmh2_pkg and murmur2_stream_hash
`default_nettype none

module tb_top;
    import mmh2_pkg::*;

    localparam int unsigned SETTLE_CYCLES = 12;
    localparam int unsigned STALL_LIMIT = 2000;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_valid;
    logic o_ready;
    logic i_op;
    logic [WORD_W-1:0] i_total_length;
    logic [WORD_W-1:0] i_data_word;
    logic [COUNT_W-1:0] i_byte_count;
    logic i_last;
    logic o_valid;
    logic i_ready;
    logic [WORD_W-1:0] o_hash_value;
    logic i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [WORD_W-1:0] i_cfg_data;

    // predictor state
    logic [WORD_W-1:0] cur_seed;
    logic [WORD_W-1:0] cur_mult;
    logic [SHIFT_W-1:0] cur_shift;
    logic [WORD_W-1:0] acc_hash;
    logic msg_open;
    logic [WORD_W-1:0] pending_hashes[$];

    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;
    int unsigned items_sent;
    int unsigned mismatch_count;
    int unsigned quiet_cycles;

    murmur2_stream_hash dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_op           (i_op),
        .i_total_length (i_total_length),
        .i_data_word    (i_data_word),
        .i_byte_count   (i_byte_count),
        .i_last         (i_last),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_hash_value   (o_hash_value),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        i_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    function automatic logic [WORD_W-1:0] finish_hash(input logic [WORD_W-1:0] h);
        logic [WORD_W-1:0] x;
        x = h ^ (h >> FIN_SHIFT_A);
        x = x * cur_mult;
        return x ^ (x >> FIN_SHIFT_B);
    endfunction

    task automatic predict_hash(input logic op, input logic [WORD_W-1:0] len,
                                input logic [WORD_W-1:0] word,
                                input logic [COUNT_W-1:0] cnt, input logic last);
        logic [WORD_W-1:0] k;
        logic [COUNT_W-1:0] n;
        logic fin;
        fin = last;
        n = (cnt > FULL_COUNT) ? FULL_COUNT : cnt;
        if (op == OP_START) begin
            acc_hash = cur_seed ^ ((len == LEN_ALL_ONES) ? '0 : len);
            msg_open = (len != 0);
            if (len == 0) begin
                pending_hashes.push_back(finish_hash(acc_hash));
            end
        end else if (msg_open) begin
            if (n == FULL_COUNT) begin
                k = word * cur_mult;
                k = k ^ (k >> cur_shift);
                k = k * cur_mult;
                acc_hash = (acc_hash * cur_mult) ^ k;
            end else if (n != 0) begin
                // tail word always ends the message
                acc_hash = (acc_hash ^ (word & ((32'h1 << (8 * n)) - 1))) * cur_mult;
                fin = 1'b1;
            end
            if (fin) begin
                msg_open = 1'b0;
                pending_hashes.push_back(finish_hash(acc_hash));
            end
        end
    endtask

    task automatic report_mismatch(input string what, input logic [WORD_W-1:0] got,
                                   input logic [WORD_W-1:0] want);
        $display("mismatch: %0s got %08h want %08h at %0t", what, got, want, $time);
        mismatch_count++;
    endtask

    // result checker
    always @(posedge i_clk) begin
        logic [WORD_W-1:0] want;
        if (i_rst_n && o_valid === 1'b1 && i_ready) begin
            if (pending_hashes.size() == 0) begin
                report_mismatch("unexpected hash", o_hash_value, '0);
            end else begin
                want = pending_hashes.pop_front();
                if (o_hash_value !== want) begin
                    report_mismatch("hash_value", o_hash_value, want);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("timeout: no item moved for %0d cycles", STALL_LIMIT);
            $display("CHECKS FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_item(input logic op, input logic [WORD_W-1:0] len,
                             input logic [WORD_W-1:0] word,
                             input logic [COUNT_W-1:0] cnt, input logic last);
        @(negedge i_clk);
        if ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            do @(negedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_valid        <= 1'b1;
        i_op           <= op;
        i_total_length <= len;
        i_data_word    <= word;
        i_byte_count   <= cnt;
        i_last         <= last;
        do @(posedge i_clk); while (o_ready !== 1'b1);
        predict_hash(op, len, word, cnt, last);
        items_sent++;
    endtask

    task automatic send_start(input logic [WORD_W-1:0] len);
        send_item(OP_START, len, $urandom, COUNT_W'($urandom_range(0, 7)),
                  1'($urandom_range(0, 1)));
    endtask

    task automatic send_word(input logic [WORD_W-1:0] word, input logic [COUNT_W-1:0] cnt,
                             input logic last);
        send_item(OP_DATA, $urandom, word, cnt, last);
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_hashes.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic close_message_and_drain();
        send_start('0);
        drain_results();
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        case (idx)
            CFG_SEED:       cur_seed = val;
            CFG_MULTIPLIER: cur_mult = val;
            CFG_SHIFT:      cur_shift = val[SHIFT_W-1:0];
            default: ;
        endcase
    endtask

    task automatic send_random_message();
        logic [WORD_W-1:0] len;
        int unsigned pick;
        int unsigned nwords;
        int unsigned tail;
        logic [COUNT_W-1:0] cnt;
        logic fin;
        pick = $urandom_range(99);
        if (pick < 10) begin
            send_item(1'($urandom_range(0, 1)), $urandom, $urandom,
                      COUNT_W'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
            return;
        end
        if (pick < 15) len = '0;
        else if (pick < 20) len = LEN_ALL_ONES;
        else if (pick < 25) len = $urandom;
        else len = $urandom_range(1, 24);
        send_start(len);
        if (len == 0) return;
        if (len <= 24) begin
            nwords = (len + 3) / 4;
            tail = len % 4;
        end else begin
            nwords = $urandom_range(1, 6);
            tail = $urandom_range(0, 3);
        end
        for (int i = 0; i < nwords; i++) begin
            fin = (i == nwords - 1);
            cnt = (fin && tail != 0) ? COUNT_W'(tail) : FULL_COUNT;
            // broken ending: odd byte count or missing last flag
            if (fin && $urandom_range(99) < 15) begin
                cnt = COUNT_W'($urandom_range(0, 7));
                fin = 1'($urandom_range(0, 1));
            end
            send_word($urandom, cnt, fin);
        end
    endtask

    task automatic test_directed_cases();
        // empty message
        send_start('0);
        // length all ones keeps the message open
        send_start(LEN_ALL_ONES);
        send_word('1, FULL_COUNT, 1'b0);
        send_word('0, FULL_COUNT, 1'b1);
        // well-formed seven bytes
        send_start(32'd7);
        send_word(32'h0403_0201, FULL_COUNT, 1'b0);
        send_word(32'hAA07_0605, 3'd3, 1'b1);
        // start while open
        send_start(32'd5);
        send_start(32'd2);
        send_word(32'hFFFF_BEEF, 3'd2, 1'b1);
        // data while closed
        send_word($urandom, FULL_COUNT, 1'b1);
        // partial word not marked last, then a word after the close
        send_start(32'd9);
        send_word(32'h1234_5678, 3'd1, 1'b0);
        send_word($urandom, FULL_COUNT, 1'b1);
        // zero byte count
        send_start(32'd4);
        send_word($urandom, 3'd0, 1'b0);
        send_word($urandom, 3'd0, 1'b1);
        // byte count above four
        send_start(32'd8);
        send_word($urandom, 3'd5, 1'b0);
        send_word($urandom, 3'd7, 1'b1);
        // length mismatch
        send_start(32'd100);
        send_word($urandom, FULL_COUNT, 1'b1);
        // single byte with junk above it
        send_start(32'd1);
        send_word(32'hC3C3_C3A5, 3'd1, 1'b1);
    endtask

    task automatic test_config_extremes();
        close_message_and_drain();
        cfg_write(CFG_SEED, '1);
        cfg_write(CFG_MULTIPLIER, '0);
        cfg_write(CFG_SHIFT, $urandom & ~32'h1F);
        repeat (5) send_random_message();
        close_message_and_drain();
        cfg_write(CFG_SEED, '0);
        cfg_write(CFG_MULTIPLIER, '1);
        cfg_write(CFG_SHIFT, ($urandom & ~32'h1F) | 32'd31);
        repeat (5) send_random_message();
        close_message_and_drain();
        cfg_write(CFG_MULTIPLIER, 32'd1);
        cfg_write(CFG_SPARE, $urandom);
        repeat (4) send_random_message();
    endtask

    task automatic test_random_traffic(input int unsigned idle_pct, input int unsigned stall_pct,
                                       input int unsigned n_items);
        int unsigned first;
        logic paused;
        close_message_and_drain();
        cfg_write(CFG_SEED, $urandom);
        cfg_write(CFG_MULTIPLIER, ($urandom_range(0, 3) == 0) ? MULT_RESET : $urandom);
        cfg_write(CFG_SHIFT, $urandom);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        first = items_sent;
        paused = 1'b0;
        while (items_sent - first < n_items) begin
            send_random_message();
            // hold off until every hash is back
            if (!paused && items_sent - first >= n_items / 2) begin
                drain_results();
                paused = 1'b1;
            end
        end
    endtask

    initial begin
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_op           = OP_START;
        i_total_length = '0;
        i_data_word    = '0;
        i_byte_count   = '0;
        i_last         = 1'b0;
        i_ready        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_index    = CFG_SEED;
        i_cfg_data     = '0;
        cur_seed       = SEED_RESET;
        cur_mult       = MULT_RESET;
        cur_shift      = SHIFT_RESET;
        acc_hash       = '0;
        msg_open       = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        items_sent     = 0;
        mismatch_count = 0;
        quiet_cycles   = 0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_cases();
        test_config_extremes();
        test_random_traffic(0, 0, 140);
        test_random_traffic(88, 0, 140);
        test_random_traffic(0, 88, 140);
        test_random_traffic(28, 28, 140);
        close_message_and_drain();

        if (mismatch_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
